FILE: design/olisr_pkg.sv
// Package for the ordered list unit: operation and status codes, controller states,
// the control word broadcast to the cell row, and the default capacity.
// No dependencies.
package olisr_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 2'd0,
        FN_REMOVE  = 2'd1,
        FN_SEARCH  = 2'd2,
        FN_DISPLAY = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE   = 2'd0,
        STS_FULL   = 2'd1,
        STS_ABSENT = 2'd2,
        STS_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DISP = 2'b10
    } state_t;

    // broadcast to every cell each cycle
    typedef struct packed {
        logic insert;   // first free slot, just past the tail, takes the operand
        logic remove;   // cells at and after the first match take their neighbour
        logic rotate;   // row moves up one place, head wraps to the tail
    } cell_ctrl_t;

endpackage

FILE: design/olisr_cell.sv
// One storage cell of the ordered list row: holds one word, compares it with
// the operand and shifts in its neighbour's word. Depends on olisr_pkg.
module olisr_cell (
    input  logic                                 clk,
    input  olisr_pkg::cell_ctrl_t                ctrl,
    input  logic signed [olisr_pkg::VALUE_W-1:0] operand,
    input  logic signed [olisr_pkg::VALUE_W-1:0] head_value,
    input  logic signed [olisr_pkg::VALUE_W-1:0] next_value,
    input  logic                                 occupied,
    input  logic                                 at_count,
    input  logic                                 at_tail,
    input  logic                                 hit_in,
    output logic                                 hit_out,
    output logic signed [olisr_pkg::VALUE_W-1:0] value
);
    import olisr_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      hit;

    assign hit     = occupied && (value_reg == operand);
    assign hit_out = hit_in || hit;
    assign value   = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert && at_count)
        begin
            value_next = operand;
        end
        else if (ctrl.remove && (hit_in || hit))
        begin
            value_next = next_value;
        end
        else if (ctrl.rotate)
        begin
            value_next = at_tail ? head_value : next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: design/ordered_list_insert_remove_search_unit.sv
// Top level of the ordered list unit: a row of olisr_cell storage cells and
// the controller that drives them. Depends on olisr_pkg and olisr_cell.
//
// Usage
//   Command channel: a word (func, operand_value) is taken at a rising edge
//   with start high and busy low.
//   Result channel: each result word is on the result ports for one cycle,
//   marked by strobe; the receiver must take it then, it cannot stall.
//   Insert, remove and search give their single result word in the
//   cycle after the command is taken; a fresh command may be issued every
//   cycle while busy is low. Every cell compares its word with the operand at once, and a
//   first-match chain down the row picks the cells that close the gap.
//   Display of n stored words: busy is high while the row rotates one place a
//   cycle past the head; result words are registered and follow the
//   rotation, head first, last marking the final one. The row is back in order
//   once every stored word has passed the head. An empty list gives one result
//   with status empty. So a display keeps busy high through the rotations of
//   the row; an empty list never raises busy.
//   Reset: the count of stored words clears and the controller goes idle;
//   the cell contents are not reset and are never shown before written.
module ordered_list_insert_remove_search_unit
#(
    parameter int CAPACITY = olisr_pkg::DEFAULT_CAPACITY
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [olisr_pkg::FUNC_W-1:0]           func,
    input  logic signed [olisr_pkg::VALUE_W-1:0]   operand_value,
    output logic                                   strobe,
    output logic [olisr_pkg::STATUS_W-1:0]         status,
    output logic                                   found,
    output logic signed [olisr_pkg::VALUE_W-1:0]   entry_value,
    output logic [olisr_pkg::POS_W-1:0]            entry_position,
    output logic [olisr_pkg::COUNT_W-1:0]          entry_count,
    output logic                                   last
);
    import olisr_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;

    logic                strobe_reg, strobe_next;
    status_t             status_reg, status_next;
    logic                found_reg, found_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [IDX_W-1:0]    opos_reg, opos_next;
    logic [CNT_W-1:0]    ocount_reg, ocount_next;
    logic                last_reg, last_next;

    cell_ctrl_t          ctrl;
    logic                accept;
    func_t               fn;
    logic                any_hit;
    logic                disp_last;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY:0]         hit_chain;

    assign busy   = (state_reg == ST_DISP);
    assign accept = start && !busy;
    assign fn     = func_t'(func);

    // cell row
    assign hit_chain[0] = 1'b0;
    assign any_hit      = hit_chain[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] nbr;
        if (i == CAPACITY - 1)
        begin : g_end
            assign nbr = cell_value[i];
        end
        else
        begin : g_mid
            assign nbr = cell_value[i+1];
        end

        olisr_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .operand    (operand_value),
            .head_value (cell_value[0]),
            .next_value (nbr),
            .occupied   (CNT_W'(i) < count_reg),
            .at_count   (CNT_W'(i) == count_reg),
            .at_tail    (CNT_W'(i + 1) == count_reg),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .value      (cell_value[i])
        );
    end

    assign disp_last = (CNT_W'(pos_reg) + CNT_W'(1)) == count_reg;

    // controller
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        ctrl        = '0;
        strobe_next = 1'b0;
        status_next = STS_DONE;
        found_next  = 1'b0;
        value_next  = '0;
        opos_next   = '0;
        ocount_next = count_reg;
        last_next   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    strobe_next = 1'b1;
                    case (fn)
                        FN_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                ctrl.insert = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                ocount_next = count_next;
                            end
                        end
                        FN_REMOVE:
                        begin
                            ctrl.remove = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else if (!any_hit)
                            begin
                                status_next = STS_ABSENT;
                            end
                            else
                            begin
                                count_next  = count_reg - CNT_W'(1);
                                ocount_next = count_next;
                            end
                        end
                        FN_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else if (!any_hit)
                            begin
                                status_next = STS_ABSENT;
                            end
                            else
                            begin
                                found_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                // results come from the display state
                                strobe_next = 1'b0;
                                pos_next    = '0;
                                state_next  = ST_DISP;
                            end
                        end
                    endcase
                end
            end
            ST_DISP:
            begin
                ctrl.rotate = 1'b1;
                strobe_next = 1'b1;
                value_next  = cell_value[0];
                opos_next   = pos_reg;
                last_next   = disp_last;
                pos_next    = pos_reg + IDX_W'(1);
                if (disp_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    // result word and display position, no reset needed
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        value_reg  <= value_next;
        opos_reg   <= opos_next;
        ocount_reg <= ocount_next;
        last_reg   <= last_next;
    end

    assign strobe         = strobe_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign entry_value    = value_reg;
    assign entry_position = POS_W'(opos_reg);
    assign entry_count    = COUNT_W'(ocount_reg);
    assign last           = last_reg;

endmodule

FILE: test/ordered_list_insert_remove_search_unit_test.sv
`timescale 1ns / 100ps
// Testbench for ordered_list_insert_remove_search_unit: directed and random command words,
// checked against an in-bench list predictor. Depends on olisr_pkg and the unit's RTL.
module ordered_list_insert_remove_search_unit_test;
    import olisr_pkg::*;

    localparam int LIST_DEPTH   = DEFAULT_CAPACITY;
    localparam int RANDOM_WORDS = 350;
    localparam int DRAIN_LIMIT  = 4000;   // cycles allowed for the final results
    localparam int SETTLE_WAIT  = 24;     // a full display plus a little margin

    // One expected result word, at the unit's port widths.
    typedef struct {
        status_t                    status;
        logic                       found;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           pos;
        logic [COUNT_W-1:0]         count;
        logic                       last;
    } list_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [FUNC_W-1:0]          func = FN_INSERT;
    logic signed [VALUE_W-1:0]  operand_value = '0;
    logic                       strobe;
    logic [STATUS_W-1:0]        status;
    logic                       found;
    logic signed [VALUE_W-1:0]  entry_value;
    logic [POS_W-1:0]           entry_position;
    logic [COUNT_W-1:0]         entry_count;
    logic                       last;

    // Predictor state: the stored list, head first, and result words still owed.
    logic signed [VALUE_W-1:0]  list_copy[$];
    list_result_t               owed_results[$];

    int  failures        = 0;
    int  words_sent      = 0;
    int  results_checked = 0;
    int  full_rejects    = 0;
    int  search_hits     = 0;
    int  displays        = 0;
    int  peak_length     = 0;
    bit  burst_mode      = 1'b0;   // no idling between words while set

    ordered_list_insert_remove_search_unit #(
        .CAPACITY(LIST_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .operand_value (operand_value),
        .strobe        (strobe),
        .status        (status),
        .found         (found),
        .entry_value   (entry_value),
        .entry_position(entry_position),
        .entry_count   (entry_count),
        .last          (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one accepted command word to the list copy and
    // queues every result word it causes.
    // ------------------------------------------------------------------
    function automatic void apply_list_command(func_t op, logic signed [VALUE_W-1:0] v);
        list_result_t r;
        int           hit;
        hit = -1;
        foreach (list_copy[i])
            if (hit < 0 && list_copy[i] == v)
                hit = i;    // first match only
        r.status = STS_DONE;
        r.found  = 1'b0;
        r.value  = '0;
        r.pos    = '0;
        r.last   = 1'b1;
        case (op)
            FN_INSERT:
            begin
                if (list_copy.size() >= LIST_DEPTH)
                begin
                    r.status = STS_FULL;
                    full_rejects++;
                end
                else
                    list_copy.push_back(v);
            end
            FN_REMOVE:
            begin
                if (list_copy.size() == 0)
                    r.status = STS_EMPTY;
                else if (hit < 0)
                    r.status = STS_ABSENT;
                else
                    list_copy.delete(hit);   // later words close the gap
            end
            FN_SEARCH:
            begin
                if (list_copy.size() == 0)
                    r.status = STS_EMPTY;
                else if (hit < 0)
                    r.status = STS_ABSENT;
                else
                begin
                    r.found = 1'b1;
                    search_hits++;
                end
            end
            default:
            begin
                displays++;
                if (list_copy.size() == 0)
                    r.status = STS_EMPTY;
            end
        endcase
        r.count = COUNT_W'(list_copy.size());
        if (list_copy.size() > peak_length)
            peak_length = list_copy.size();
        // a display of a non-empty list gives one word per entry, head first
        if (op == FN_DISPLAY && list_copy.size() != 0)
        begin
            foreach (list_copy[i])
            begin
                r.value = list_copy[i];
                r.pos   = POS_W'(i);
                r.last  = (i == list_copy.size() - 1);
                owed_results.push_back(r);
            end
        end
        else
            owed_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobed word against the oldest one owed.
    // Outputs are read at the edge that ends the strobe cycle.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && strobe)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result word with none owed: status %0d count %0d", status,
                       entry_count);
                failures++;
            end
            else
            begin
                want = owed_results.pop_front();
                results_checked++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    failures++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    failures++;
                end
                if (entry_value !== want.value)
                begin
                    $error("entry_value: expected %0d, got %0d", want.value, entry_value);
                    failures++;
                end
                if (entry_position !== want.pos)
                begin
                    $error("entry_position: expected %0d, got %0d", want.pos,
                           entry_position);
                    failures++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                    failures++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    failures++;
                end
            end
        end
    end

    // Picks the idle gap before a word: no gap in a burst, else a random one.
    function automatic int pick_gap();
        if (burst_mode)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    // Drives one command word and holds it until the unit takes it.
    // start is only lowered when there is a gap, so it never toggles in one step.
    task automatic send_word(input func_t op, input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            func  <= func_t'($urandom_range(0, 3));   // noise while idle
            operand_value <= $urandom;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        func          <= op;
        operand_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_list_command(op, v);
        words_sent++;
    endtask

    // Holds off until every owed result word has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Operand for random traffic: mostly stored values or a small pool, so hits
    // and duplicates are common; the rest are wide or extreme values.
    function automatic logic signed [VALUE_W-1:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 4 && list_copy.size() != 0)
            return list_copy[$urandom_range(0, list_copy.size() - 1)];
        if (sel <= 7)
            return $signed($urandom_range(0, 7)) - 4;
        if (sel == 8)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Remove, search and display on an empty list.
    task automatic test_empty_list();
        send_word(FN_REMOVE, 32'sd5);
        send_word(FN_SEARCH, -1);
        send_word(FN_DISPLAY, 32'sh7FFF_FFFF);
        send_word(FN_SEARCH, '0);
    endtask

    // Fill to capacity with extremes and a duplicate, then try one more and display the list.
    task automatic test_fill_and_reject();
        send_word(FN_INSERT, 32'sh8000_0000);
        send_word(FN_INSERT, 32'sh7FFF_FFFF);
        send_word(FN_INSERT, '0);
        send_word(FN_INSERT, -1);
        send_word(FN_INSERT, 32'sh5555_5555);
        send_word(FN_INSERT, 32'shAAAA_AAAA);
        send_word(FN_INSERT, 32'sd7);
        send_word(FN_INSERT, 32'sd7);
        while (list_copy.size() < LIST_DEPTH)
            send_word(FN_INSERT, $urandom);
        send_word(FN_INSERT, 32'sd123);   // rejected: list full
        send_word(FN_DISPLAY, '0);
    endtask

    // Hits, misses, first-of-duplicates removal, head, tail and absent removal, then a display.
    task automatic test_remove_and_search();
        send_word(FN_SEARCH, 32'sd7);
        send_word(FN_SEARCH, 32'sd9999);
        send_word(FN_REMOVE, 32'sd7);              // only the first 7 goes
        send_word(FN_REMOVE, 32'sh8000_0000);      // head
        send_word(FN_REMOVE, list_copy[$]);        // tail
        send_word(FN_REMOVE, 32'sd4242);           // absent
        send_word(FN_DISPLAY, 32'sd1);
    endtask

    // Random traffic, alternating between growing and shrinking spells so the
    // list swings between empty and full.
    task automatic test_random_traffic();
        bit    growing;
        int    roll;
        func_t op;
        growing = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
                growing = !growing;
            if (n % 32 == 16)
                burst_mode = !burst_mode;
            if ($urandom_range(0, 24) == 0)
                wait_for_results();
            roll = $urandom_range(0, 99);
            if (roll < (growing ? 50 : 20))
                op = FN_INSERT;
            else if (roll < 70)
                op = FN_REMOVE;
            else if (roll < 90)
                op = FN_SEARCH;
            else
                op = FN_DISPLAY;
            send_word(op, pick_operand());
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        int waited;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_fill_and_reject();
        wait_for_results();   // full stop with the list at its fullest
        test_remove_and_search();
        test_random_traffic();

        start  <= 1'b0;
        waited = 0;
        while (owed_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (owed_results.size() != 0)
        begin
            $error("%0d result words never arrived", owed_results.size());
            failures++;
        end
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("%0d command words, %0d result words checked, %0d displays,",
                 words_sent, results_checked, displays);
        $display("%0d full rejections, %0d search hits, peak length %0d",
                 full_rejects, search_hits, peak_length);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog well past the slowest legal run.
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
